[hw/rtl/gbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants, box record and controller/datapath link types for the
// greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int MAX_KEPT   = 64;
    localparam int INDEX_BITS = 12;
    localparam int KEPT_W     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int COUNT_W    = $clog2(MAX_KEPT + 1);
    localparam int IDX_OUT_W  = 12;
    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 15;
    localparam int THR_W      = 9;
    localparam int AREA_W     = 2 * SIZE_W;
    localparam int UNION_W    = AREA_W + 1;
    localparam int PROD_W     = THR_W + UNION_W;
    localparam int STAGES     = 5;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(115);

    typedef struct packed {
        logic [SIZE_W-1:0]         height;
        logic [SIZE_W-1:0]         width;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] left;
    } box_t;

    typedef struct packed {
        logic              start;
        logic              rd_en;
        logic [KEPT_W-1:0] rd_addr;
        logic              finish;
    } gbs_cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] kept_count;
        logic               pipe_busy;
        logic               out_free;
    } gbs_status_t;

endpackage

[hw/rtl/gbs_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_ifs
// Valid/ready channels for incoming boxes and suppression results.
// ----------------------------------------------------------------------------
interface gbs_box_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic [14:0]       box_width;
    logic [14:0]       box_height;
    logic              last_in_set;

    modport source (output valid, box_left, box_top, box_width, box_height, last_in_set,
                    input ready);
    modport sink   (input valid, box_left, box_top, box_width, box_height, last_in_set,
                    output ready);
endinterface

interface gbs_result_if;
    logic        valid;
    logic        ready;
    logic        keep;
    logic [11:0] box_index;
    logic        store_overflow;

    modport source (output valid, keep, box_index, store_overflow, input ready);
    modport sink   (input valid, keep, box_index, store_overflow, output ready);
endinterface

[hw/rtl/greedy_box_suppression.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy IoU suppression of score-sorted boxes against the boxes kept so
// far in the current set.
//
//   channel   dir   payload                                         handshake
//   in_box    in    box_left, box_top, box_width, box_height,       valid/ready
//                   last_in_set
//   out_res   out   keep, box_index, store_overflow                 valid/ready
//   cfg       in    cfg_wr_data (overlap threshold)                 cfg_wr_en
//
// Each item passes through idle, scan, drain and finish. Scan makes N store
// reads, one kept box per cycle, N being the number of boxes kept so far in
// the set (at most 64); drain waits for the compare pipeline to empty; finish
// commits the result to the output register and returns to idle. With N = 0
// the scan and drain are skipped. No clearing pass is needed after reset.
// A new item is taken while the previous result waits in the output register;
// a stalled output holds the block once the next result is ready.
// ----------------------------------------------------------------------------
module greedy_box_suppression
    import gbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [THR_W-1:0]  cfg_wr_data,
    gbs_box_if.sink           in_box,
    gbs_result_if.source      out_res
);

    gbs_cmd_t    cmd;
    gbs_status_t status;

    gbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_box.valid),
        .in_ready (in_box.ready),
        .status   (status),
        .cmd      (cmd)
    );

    gbs_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .status         (status),
        .box_left       (in_box.box_left),
        .box_top        (in_box.box_top),
        .box_width      (in_box.box_width),
        .box_height     (in_box.box_height),
        .last_in_set    (in_box.last_in_set),
        .out_valid      (out_res.valid),
        .out_ready      (out_res.ready),
        .keep           (out_res.keep),
        .box_index      (out_res.box_index),
        .store_overflow (out_res.store_overflow)
    );

endmodule

[hw/rtl/gbs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_ctrl
// Sequencer: accepts a box, walks the kept-box store one entry a cycle,
// waits for the compare pipeline to drain and commits the result.
// ----------------------------------------------------------------------------
module gbs_ctrl
    import gbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  gbs_status_t status,
    output gbs_cmd_t    cmd
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DRAIN,
        FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [KEPT_W-1:0] addr_reg, addr_next;
    logic              scan_last;

    assign in_ready  = (state_reg == IDLE);
    assign scan_last = (COUNT_W'({1'b0, addr_reg}) + COUNT_W'(1)) == status.kept_count;

    always_comb
    begin
        cmd.start   = in_valid && in_ready;
        cmd.rd_en   = (state_reg == SCAN);
        cmd.rd_addr = addr_reg;
        cmd.finish  = (state_reg == FINISH) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            IDLE:
            begin
                addr_next = '0;
                if (in_valid)
                begin
                    if (status.kept_count == '0)
                        state_next = FINISH;
                    else
                        state_next = SCAN;
                end
            end
            SCAN:
            begin
                addr_next = addr_reg + KEPT_W'(1);
                if (scan_last)
                    state_next = DRAIN;
            end
            DRAIN:
            begin
                if (!status.pipe_busy)
                    state_next = FINISH;
            end
            FINISH:
            begin
                if (status.out_free)
                    state_next = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

endmodule

[hw/rtl/gbs_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_datapath
// Kept-box store, five-stage overlap compare pipeline, threshold register,
// counters and the result register.
// ----------------------------------------------------------------------------
module gbs_datapath
    import gbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [THR_W-1:0]          cfg_wr_data,
    input  gbs_cmd_t                  cmd,
    output gbs_status_t               status,
    input  logic signed [COORD_W-1:0] box_left,
    input  logic signed [COORD_W-1:0] box_top,
    input  logic [SIZE_W-1:0]         box_width,
    input  logic [SIZE_W-1:0]         box_height,
    input  logic                      last_in_set,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      keep,
    output logic [IDX_OUT_W-1:0]      box_index,
    output logic                      store_overflow
);

    box_t                   store_mem [MAX_KEPT];

    logic [THR_W-1:0]       thr_reg;
    box_t                   a_reg;
    logic                   last_reg;
    logic [AREA_W-1:0]      a_area_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [INDEX_BITS-1:0]  pos_reg;
    logic                   suppress_reg;
    logic [STAGES-1:0]      vld_reg;

    box_t                   rd_reg;
    logic [SIZE_W-1:0]      dx_reg, dy_reg, bw_reg, bh_reg;
    logic [AREA_W-1:0]      inter2_reg, b_area_reg;
    logic [AREA_W-1:0]      inter3_reg;
    logic [UNION_W-1:0]     union_reg;
    logic [AREA_W-1:0]      inter4_reg;
    logic [PROD_W-1:0]      prod_reg;

    logic                   out_valid_reg;
    logic                   keep_reg, ovf_reg;
    logic [INDEX_BITS-1:0]  idx_reg;

    logic signed [COORD_W:0]   a_right, b_right, a_bottom, b_bottom;
    logic signed [COORD_W-1:0] x1, y1;
    logic signed [COORD_W:0]   x2, y2;
    logic signed [COORD_W+1:0] dx_full, dy_full;
    logic                      overlap;
    logic                      survive, full, keep_now;
    logic                      out_take;

    // geometry of the new box against the stored one
    always_comb
    begin
        a_right  = $signed({a_reg.left[COORD_W-1], a_reg.left}) + $signed({2'b00, a_reg.width});
        b_right  = $signed({rd_reg.left[COORD_W-1], rd_reg.left})
                 + $signed({2'b00, rd_reg.width});
        a_bottom = $signed({a_reg.top[COORD_W-1], a_reg.top}) + $signed({2'b00, a_reg.height});
        b_bottom = $signed({rd_reg.top[COORD_W-1], rd_reg.top})
                 + $signed({2'b00, rd_reg.height});
        x1 = (a_reg.left > rd_reg.left) ? a_reg.left : rd_reg.left;
        y1 = (a_reg.top  > rd_reg.top)  ? a_reg.top  : rd_reg.top;
        x2 = (a_right  < b_right)  ? a_right  : b_right;
        y2 = (a_bottom < b_bottom) ? a_bottom : b_bottom;
        dx_full = $signed({x2[COORD_W], x2}) - $signed({{2{x1[COORD_W-1]}}, x1});
        dy_full = $signed({y2[COORD_W], y2}) - $signed({{2{y1[COORD_W-1]}}, y1});
        overlap = (dx_full > 0) && (dy_full > 0);
    end

    assign full     = (count_reg == COUNT_W'(MAX_KEPT));
    assign survive  = !suppress_reg;
    assign keep_now = survive && !full;
    assign out_take = out_valid_reg && out_ready;

    always_comb
    begin
        status.kept_count = count_reg;
        status.pipe_busy  = |vld_reg;
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign keep           = keep_reg;
    assign store_overflow = ovf_reg;
    assign box_index      = IDX_OUT_W'(idx_reg);

    // store: one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.finish && keep_now)
            store_mem[count_reg[KEPT_W-1:0]] <= a_reg;
        if (cmd.rd_en)
            rd_reg <= store_mem[cmd.rd_addr];
    end

    // compare pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg.left   <= box_left;
            a_reg.top    <= box_top;
            a_reg.width  <= box_width;
            a_reg.height <= box_height;
            last_reg     <= last_in_set;
        end
        a_area_reg <= a_reg.width * a_reg.height;

        dx_reg <= overlap ? dx_full[SIZE_W-1:0] : '0;
        dy_reg <= overlap ? dy_full[SIZE_W-1:0] : '0;
        bw_reg <= rd_reg.width;
        bh_reg <= rd_reg.height;

        inter2_reg <= dx_reg * dy_reg;
        b_area_reg <= bw_reg * bh_reg;

        // intersection never exceeds either area, so the union stays non-negative
        union_reg  <= {1'b0, a_area_reg} + {1'b0, b_area_reg} - {1'b0, inter2_reg};
        inter3_reg <= inter2_reg;

        prod_reg   <= thr_reg * union_reg;
        inter4_reg <= inter3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THR_RESET;
            vld_reg       <= '0;
            suppress_reg  <= 1'b0;
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            keep_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;

            vld_reg <= {vld_reg[STAGES-2:0], cmd.rd_en};

            // a zero union forces a zero intersection, so it never suppresses
            if (cmd.start)
                suppress_reg <= 1'b0;
            else if (vld_reg[STAGES-1] &&
                     (PROD_W'({inter4_reg, 8'h00}) > prod_reg))
                suppress_reg <= 1'b1;

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                keep_reg      <= keep_now;
                ovf_reg       <= survive && full;
                idx_reg       <= pos_reg;
                if (last_reg)
                begin
                    count_reg <= '0;
                    pos_reg   <= '0;
                end
                else
                begin
                    count_reg <= count_reg + COUNT_W'(keep_now);
                    pos_reg   <= pos_reg + INDEX_BITS'(1);
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_KEPT))
        else $error("kept count beyond store depth");

    a_keep_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(keep_reg && ovf_reg))
        else $error("keep and overflow both set");

    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (COUNT_W'({1'b0, cmd.rd_addr}) < count_reg))
        else $error("store read beyond kept entries");

    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (vld_reg == '0) && !cmd.rd_en)
        else $error("result committed with compares in flight");

endmodule

[tb/sv/greedy_box_suppression_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression_tb
// Streams score-sorted box sets into the suppression block over valid/ready
// and checks every result against an in-bench model of greedy IoU
// suppression or, for typed table rows, a hand-typed verdict. A short table
// of hand-picked boxes comes first, then random sets under three idling mixes.
// ----------------------------------------------------------------------------
module greedy_box_suppression_tb;
    import gbs_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RAND_ITEMS   = 1300;
    localparam int MAX_REPORTS  = 10;
    localparam int NO_WRITE     = -1;
    localparam int N_DIR        = 21;

    typedef struct packed {
        logic        keep;
        logic [11:0] box_index;
        logic        store_overflow;
    } verdict_t;

    typedef struct {
        int thr;
        int left;
        int top;
        int width;
        int height;
        bit last;
        bit typed;
        bit keep;
        int idx;
        bit ovf;
    } dir_row_t;

    // thr, left, top, width, height, last, typed, keep, idx, ovf
    dir_row_t dir_rows [N_DIR] = '{
        '{NO_WRITE, 0, 0, 256, 256, 0, 1, 1, 0, 0},
        '{NO_WRITE, 0, 0, 256, 256, 0, 1, 0, 1, 0},
        '{NO_WRITE, -32768, -32768, 32767, 32767, 0, 1, 1, 2, 0},
        '{NO_WRITE, 32767, 32767, 32767, 32767, 0, 1, 1, 3, 0},
        '{NO_WRITE, 16, 16, 0, 256, 0, 1, 1, 4, 0},
        '{NO_WRITE, 16, 16, 0, 256, 0, 1, 1, 5, 0},
        '{NO_WRITE, 128, 0, 256, 256, 0, 0, 0, 0, 0},
        '{NO_WRITE, 8, 8, 256, 256, 0, 0, 0, 0, 0},
        '{NO_WRITE, -32768, 32767, 32767, 0, 0, 0, 0, 0, 0},
        '{NO_WRITE, 100, 100, 50, 50, 1, 0, 0, 0, 0},
        '{256, 0, 0, 256, 256, 0, 1, 1, 0, 0},
        '{NO_WRITE, 0, 0, 256, 256, 0, 1, 1, 1, 0},
        '{NO_WRITE, 0, 0, 256, 256, 1, 1, 1, 2, 0},
        '{0, 0, 0, 256, 256, 0, 1, 1, 0, 0},
        '{NO_WRITE, 255, 255, 256, 256, 0, 1, 0, 1, 0},
        '{NO_WRITE, 256, 0, 256, 256, 0, 1, 1, 2, 0},
        '{NO_WRITE, 32767, -32768, 32767, 32767, 1, 0, 0, 0, 0},
        '{115, -1, -1, 1, 1, 1, 1, 1, 0, 0},
        '{128, 0, 0, 32, 16, 0, 1, 1, 0, 0},
        '{NO_WRITE, 0, 0, 16, 16, 0, 0, 0, 0, 0},
        '{NO_WRITE, 0, 0, 32, 16, 1, 0, 0, 0, 0}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [THR_W-1:0] cfg_wr_data;

    gbs_box_if    in_box ();
    gbs_result_if out_res ();

    greedy_box_suppression dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_box      (in_box),
        .out_res     (out_res)
    );

    // model state
    box_t     kept_store [MAX_KEPT];
    int       kept_n;
    int       set_pos;
    int       thr_model;
    verdict_t verdict_q [$];

    // typed verdict for directed rows, driven alongside the payload
    bit       row_typed;
    verdict_t row_verdict;

    int send_idle_pct;
    int recv_idle_pct;
    bit stall_request;
    int mismatches;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit overlaps_above(box_t a, box_t b);
        longint al, at, aw, ah, bl, bt, bw, bh;
        longint x1, y1, x2, y2, inter, uni;
        al = longint'(a.left);
        at = longint'(a.top);
        aw = longint'(a.width);
        ah = longint'(a.height);
        bl = longint'(b.left);
        bt = longint'(b.top);
        bw = longint'(b.width);
        bh = longint'(b.height);
        x1 = (al > bl) ? al : bl;
        y1 = (at > bt) ? at : bt;
        x2 = (al + aw < bl + bw) ? al + aw : bl + bw;
        y2 = (at + ah < bt + bh) ? at + ah : bt + bh;
        inter = 0;
        if (x2 > x1 && y2 > y1)
            inter = (x2 - x1) * (y2 - y1);
        uni = aw * ah + bw * bh - inter;
        if (uni <= 0)
            return 1'b0;
        return inter * 256 > longint'(thr_model) * uni;
    endfunction

    function automatic verdict_t predict_box(box_t b, bit last);
        verdict_t v;
        bit       survive;
        survive = 1'b1;
        for (int i = 0; i < kept_n; i++)
            if (overlaps_above(b, kept_store[i]))
                survive = 1'b0;
        v.keep           = 1'b0;
        v.store_overflow = 1'b0;
        v.box_index      = 12'(set_pos);
        if (survive)
        begin
            if (kept_n < MAX_KEPT)
            begin
                kept_store[kept_n] = b;
                kept_n++;
                v.keep = 1'b1;
            end
            else
                v.store_overflow = 1'b1;
        end
        if (last)
        begin
            set_pos = 0;
            kept_n  = 0;
        end
        else
            set_pos = (set_pos + 1) % (1 << INDEX_BITS);
        return v;
    endfunction

    // check the outgoing result first, then predict the incoming item
    always @(posedge clk)
    begin
        box_t     acc_box;
        verdict_t want;
        if (rst_n && out_res.valid && out_res.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: keep=%0b index=%0d overflow=%0b",
                             out_res.keep, out_res.box_index, out_res.store_overflow);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (out_res.keep !== want.keep || out_res.box_index !== want.box_index ||
                    out_res.store_overflow !== want.store_overflow)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("want keep/idx/ovf %0b/%0d/%0b, got %0b/%0d/%0b",
                                 want.keep, want.box_index, want.store_overflow,
                                 out_res.keep, out_res.box_index, out_res.store_overflow);
                end
            end
        end
        if (rst_n && in_box.valid && in_box.ready)
        begin
            acc_box.left   = in_box.box_left;
            acc_box.top    = in_box.box_top;
            acc_box.width  = in_box.box_width;
            acc_box.height = in_box.box_height;
            want = predict_box(acc_box, in_box.last_in_set);
            if (row_typed)
                want = row_verdict;
            verdict_q = {verdict_q, want};
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left     = 0;
        out_res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                hold_left     = HOLD_CYCLES;
                stall_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_res.ready <= 1'b0;
            end
            else
                out_res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // entered and left at a falling edge; valid stays high after the item
    task automatic send_box(box_t b, bit last, bit typed, verdict_t v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_box.valid <= 1'b0;
            @(negedge clk);
        end
        in_box.valid       <= 1'b1;
        in_box.box_left    <= b.left;
        in_box.box_top     <= b.top;
        in_box.box_width   <= b.width;
        in_box.box_height  <= b.height;
        in_box.last_in_set <= last;
        row_typed          <= typed;
        row_verdict        <= v;
        @(posedge clk);
        while (!in_box.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain;
        in_box.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_threshold(int value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= THR_W'(value);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        thr_model    = value;
    endtask

    task automatic random_set(ref int sent);
        int   kind, len, cx, cy, span;
        box_t b;
        bit   last;
        kind = $urandom_range(0, 15);
        case (kind)
            11, 12:  len = $urandom_range(2, 16);
            13:      len = $urandom_range(MAX_KEPT + 1, MAX_KEPT + 8);
            14:      len = 1;
            default: len = $urandom_range(1, 24);
        endcase
        cx   = $urandom_range(0, 40000) - 20000;
        cy   = $urandom_range(0, 40000) - 20000;
        span = $urandom_range(16, 2048);
        for (int i = 0; i < len; i++)
        begin
            // hop to a new cluster now and then
            if (kind <= 8 && $urandom_range(0, 3) == 0)
            begin
                cx = $urandom_range(0, 40000) - 20000;
                cy = $urandom_range(0, 40000) - 20000;
            end
            b.left   = 16'(cx + int'($urandom_range(0, span / 4)) - span / 8);
            b.top    = 16'(cy + int'($urandom_range(0, span / 4)) - span / 8);
            b.width  = 15'(span + int'($urandom_range(0, span / 4)));
            b.height = 15'(span + int'($urandom_range(0, span / 4)));
            last     = (i == len - 1);
            case (kind)
                9, 10:
                begin
                    b.left   = 16'($urandom);
                    b.top    = 16'($urandom);
                    b.width  = 15'($urandom);
                    b.height = 15'($urandom);
                    last     = last || ($urandom_range(0, 7) == 0);
                end
                11, 12:
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        if ($urandom_range(0, 1) == 1)
                            b.width = '0;
                        else
                            b.height = '0;
                    end
                end
                13:
                begin
                    // disjoint grid: every box survives until the store is full
                    b.left   = 16'(cx + (i % 9) * 512);
                    b.top    = 16'(cy + (i / 9) * 512);
                    b.width  = 15'(300 + $urandom_range(0, 100));
                    b.height = 15'(300 + $urandom_range(0, 100));
                end
                15:
                begin
                    b.left   = 16'(cx + int'($urandom_range(0, 3)));
                    b.top    = 16'(cy + int'($urandom_range(0, 3)));
                    b.width  = 15'(span);
                    b.height = 15'(span);
                end
                default: ;
            endcase
            send_box(b, last, 1'b0, '0);
            sent++;
        end
    endtask

    initial
    begin
        box_t     b;
        verdict_t typed_v;
        int       sent;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        in_box.valid       = 1'b0;
        in_box.box_left    = '0;
        in_box.box_top     = '0;
        in_box.box_width   = '0;
        in_box.box_height  = '0;
        in_box.last_in_set = 1'b0;
        row_typed          = 1'b0;
        row_verdict        = '0;
        stall_request      = 1'b0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        mismatches         = 0;
        cycle_count        = 0;
        kept_n             = 0;
        set_pos            = 0;
        thr_model          = int'(THR_RESET);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 30;
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].thr != NO_WRITE)
                write_threshold(dir_rows[r].thr);
            b.left                 = 16'(dir_rows[r].left);
            b.top                  = 16'(dir_rows[r].top);
            b.width                = 15'(dir_rows[r].width);
            b.height               = 15'(dir_rows[r].height);
            typed_v.keep           = dir_rows[r].keep;
            typed_v.box_index      = 12'(dir_rows[r].idx);
            typed_v.store_overflow = dir_rows[r].ovf;
            send_box(b, dir_rows[r].last, dir_rows[r].typed, typed_v);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 34;
                    recv_idle_pct = 80;
                    write_threshold(115);
                end
                1:
                begin
                    send_idle_pct = 80;
                    recv_idle_pct = 34;
                    write_threshold($urandom_range(1, 255));
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_threshold(179);
                    // block the result side while items keep coming
                    stall_request = 1'b1;
                end
            endcase
            sent = 0;
            while (sent < RAND_ITEMS / 3)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       write_threshold(0);
                        1:       write_threshold(256);
                        default: write_threshold($urandom_range(0, 256));
                    endcase
                end
                random_set(sent);
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
